// ----- design/matrix_inverse_3x3_defines.svh -----
// Assertion macros used by the matrix inverse top module
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define MI3_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mi3_pkg.sv -----
// Shared types, constants and index tables for the 3x3 matrix inverse
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int INT_BITS       = 4;
    localparam int RECIP_W        = 64;
    localparam int RND_BASE       = 46;
    localparam int OUT_W          = 32;
    localparam int NUM_ELEM       = 9;

    localparam logic [OUT_W-1:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [OUT_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef logic [OUT_W-1:0] mi3_word_t;

    // Per-stage control that travels with each item
    typedef struct packed {
        logic valid;
        logic singular;
    } mi3_ctl_t;

    // One finished result
    typedef struct packed {
        mi3_word_t [NUM_ELEM-1:0] elem;
        logic                     singular;
        logic                     saturated;
    } mi3_res_t;

    // Element indexes (row*3+col) of p, q, r, s for adjugate entry k = p*q - r*s
    function automatic logic [3:0] minor_idx(input logic [3:0] k, input logic [1:0] pos);
        logic [15:0] t;
        case (k)
            4'd0:    t = {4'd4, 4'd8, 4'd7, 4'd5};
            4'd1:    t = {4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    t = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    t = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    t = {4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    t = {4'd3, 4'd2, 4'd0, 4'd5};
            4'd6:    t = {4'd3, 4'd7, 4'd6, 4'd4};
            4'd7:    t = {4'd6, 4'd1, 4'd0, 4'd7};
            4'd8:    t = {4'd0, 4'd4, 4'd3, 4'd1};
            default: t = '0;
        endcase
        return t[4*(3-pos) +: 4];
    endfunction

    // Identity element for a singular matrix
    function automatic mi3_word_t ident_elem(input int i);
        return (i % 4 == 0) ? ONE_Q16 : '0;
    endfunction

endpackage

// ----- design/mi3_cof.sv -----
// Adjugate cofactors, determinant and magnitudes in six register stages
`timescale 1ns / 1ps

module mi3_cof #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ELEM_WIDTH-1:0]  elem [mi3_pkg::NUM_ELEM],
    output mi3_pkg::mi3_ctl_t             ctl,
    output logic [3*ELEM_WIDTH:0]         dmag,
    output logic [18*ELEM_WIDTH+8:0]      side
);

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int CM = 2 * W;
    localparam int DW = 3 * W + 2;
    localparam int NB = 3 * W + 1;
    localparam int NE = mi3_pkg::NUM_ELEM;

    logic [5:0] valid_reg;

    logic signed [PW-1:0] pq_reg [NE];
    logic signed [PW-1:0] rs_reg [NE];
    logic signed [PW-1:0] pq_next [NE];
    logic signed [PW-1:0] rs_next [NE];
    logic signed [W-1:0]  a1_reg [3];
    logic signed [W-1:0]  a2_reg [3];

    logic signed [CW-1:0] cof2_reg [NE];
    logic signed [CW-1:0] cof3_reg [NE];
    logic signed [CW-1:0] cof4_reg [NE];
    logic signed [CW-1:0] cof5_reg [NE];
    logic signed [CW-1:0] cof2_next [NE];

    logic signed [PW:0]   pl_reg [3];
    logic signed [PW:0]   ph_reg [3];
    logic signed [PW:0]   pl_next [3];
    logic signed [PW:0]   ph_next [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] term_next [3];
    logic signed [DW-1:0] det_reg;
    logic signed [DW-1:0] det_next;

    logic [NB-1:0]        dmag_reg;
    logic                 sing_reg;
    logic [CM-1:0]        mag_reg [NE];
    logic [NE-1:0]        neg_reg;
    logic signed [CW-1:0] cof_abs [NE];
    logic signed [DW-1:0] det_abs;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // Form the 2x2 products and the determinant partial products
    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            pq_next[k] = elem[mi3_pkg::minor_idx(4'(k), 2'd0)]
                       * elem[mi3_pkg::minor_idx(4'(k), 2'd1)];
            rs_next[k] = elem[mi3_pkg::minor_idx(4'(k), 2'd2)]
                       * elem[mi3_pkg::minor_idx(4'(k), 2'd3)];
            cof2_next[k] = $signed({pq_reg[k][PW-1], pq_reg[k]})
                         - $signed({rs_reg[k][PW-1], rs_reg[k]});
        end
        // Split each cofactor into an unsigned low half and a signed high part
        for (int j = 0; j < 3; j++)
        begin
            pl_next[j] = $signed({1'b0, cof2_reg[3*j][W-1:0]}) * a2_reg[j];
            ph_next[j] = $signed(cof2_reg[3*j][CW-1:W]) * a2_reg[j];
            term_next[j] = (DW'(ph_reg[j]) <<< W) + DW'(pl_reg[j]);
        end
        det_next = term_reg[0] + term_reg[1] + term_reg[2];
        det_abs  = det_reg[DW-1] ? -det_reg : det_reg;
        for (int k = 0; k < NE; k++)
        begin
            cof_abs[k] = cof5_reg[k][CW-1] ? -cof5_reg[k] : cof5_reg[k];
        end
    end

    // Hold the payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                pq_reg[k]   <= pq_next[k];
                rs_reg[k]   <= rs_next[k];
                cof2_reg[k] <= cof2_next[k];
                cof3_reg[k] <= cof2_reg[k];
                cof4_reg[k] <= cof3_reg[k];
                cof5_reg[k] <= cof4_reg[k];
                mag_reg[k]  <= cof_abs[k][CM-1:0];
                neg_reg[k]  <= cof5_reg[k][CW-1] ^ det_reg[DW-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                a1_reg[j]   <= elem[j];
                a2_reg[j]   <= a1_reg[j];
                pl_reg[j]   <= pl_next[j];
                ph_reg[j]   <= ph_next[j];
                term_reg[j] <= term_next[j];
            end
            det_reg  <= det_next;
            dmag_reg <= det_abs[NB-1:0];
            sing_reg <= (det_reg == '0);
        end
    end

    // Drive the outputs
    always_comb
    begin
        ctl.valid    = valid_reg[5];
        ctl.singular = sing_reg;
        dmag         = dmag_reg;
        for (int k = 0; k < NE; k++)
        begin
            side[CM*k +: CM] = mag_reg[k];
        end
        side[NE*CM +: NE] = neg_reg;
    end

endmodule

// ----- design/mi3_norm.sv -----
// Pipelined leading-zero normalizer for the determinant magnitude
`timescale 1ns / 1ps

module mi3_norm #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  mi3_pkg::mi3_ctl_t                   ctl_in,
    input  logic [3*ELEM_WIDTH:0]               dmag,
    input  logic [18*ELEM_WIDTH+8:0]            side_in,
    output mi3_pkg::mi3_ctl_t                   ctl_out,
    output logic [3*ELEM_WIDTH:0]               dnorm,
    output logic [$clog2(3*ELEM_WIDTH+1)-1:0]   lz,
    output logic [18*ELEM_WIDTH+8:0]            side_out
);

    localparam int NB  = 3 * ELEM_WIDTH + 1;
    localparam int NSH = $clog2(NB);
    localparam int SW  = 18 * ELEM_WIDTH + 9;

    mi3_pkg::mi3_ctl_t ctl_reg  [NSH];
    logic [NB-1:0]     x_reg    [NSH];
    logic [NSH-1:0]    lz_reg   [NSH];
    logic [SW-1:0]     side_reg [NSH];

    for (genvar g = 0; g < NSH; g++)
    begin : g_stage
        localparam int K  = NSH - 1 - g;
        localparam int SH = 1 << K;

        mi3_pkg::mi3_ctl_t ctl_cur;
        logic [NB-1:0]     x_cur;
        logic [NSH-1:0]    lz_cur;
        logic [SW-1:0]     side_cur;
        logic              zero;
        logic [NB-1:0]     x_next;
        logic [NSH-1:0]    lz_next;

        if (g == 0)
        begin : g_first
            assign ctl_cur  = ctl_in;
            assign x_cur    = dmag;
            assign lz_cur   = '0;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign ctl_cur  = ctl_reg[g-1];
            assign x_cur    = x_reg[g-1];
            assign lz_cur   = lz_reg[g-1];
            assign side_cur = side_reg[g-1];
        end

        // Shift left by this stage's weight when the top bits are all clear
        always_comb
        begin
            zero       = (x_cur[NB-1 -: SH] == '0);
            x_next     = zero ? (x_cur << SH) : x_cur;
            lz_next    = lz_cur;
            lz_next[K] = zero;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else if (en)
            begin
                ctl_reg[g] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]    <= x_next;
                lz_reg[g]   <= lz_next;
                side_reg[g] <= side_cur;
            end
        end
    end

    assign ctl_out  = ctl_reg[NSH-1];
    assign dnorm    = x_reg[NSH-1];
    assign lz       = lz_reg[NSH-1];
    assign side_out = side_reg[NSH-1];

endmodule

// ----- design/mi3_div.sv -----
// Pipelined restoring divider: one reciprocal bit per stage
`timescale 1ns / 1ps

module mi3_div #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  mi3_pkg::mi3_ctl_t                   ctl_in,
    input  logic [3*ELEM_WIDTH:0]               dnorm,
    input  logic [$clog2(3*ELEM_WIDTH+1)-1:0]   lz_in,
    input  logic [18*ELEM_WIDTH+8:0]            side_in,
    output mi3_pkg::mi3_ctl_t                   ctl_out,
    output logic [mi3_pkg::RECIP_W-1:0]         recip,
    output logic [$clog2(3*ELEM_WIDTH+1)-1:0]   lz_out,
    output logic [18*ELEM_WIDTH+8:0]            side_out
);

    localparam int NB  = 3 * ELEM_WIDTH + 1;
    localparam int NSH = $clog2(NB);
    localparam int SW  = 18 * ELEM_WIDTH + 9;
    localparam int RW  = mi3_pkg::RECIP_W;

    mi3_pkg::mi3_ctl_t ctl_reg  [RW];
    logic [NB-1:0]     rem_reg  [RW];
    logic [NB-1:0]     dn_reg   [RW];
    logic [RW-1:0]     q_reg    [RW];
    logic [NSH-1:0]    lz_reg   [RW];
    logic [SW-1:0]     side_reg [RW];

    for (genvar g = 0; g < RW; g++)
    begin : g_stage
        mi3_pkg::mi3_ctl_t ctl_cur;
        logic [NB:0]       trial;
        logic [NB-1:0]     dn_cur;
        logic [RW-1:0]     q_cur;
        logic [NSH-1:0]    lz_cur;
        logic [SW-1:0]     side_cur;
        logic              ge;
        logic [NB:0]       diff;
        logic [NB-1:0]     rem_next;
        logic [RW-1:0]     q_next;

        if (g == 0)
        begin : g_first
            // Dividend top part is 2^(NB-1); the normalized divisor is at least that
            assign trial    = {2'b01, {(NB-1){1'b0}}};
            assign ctl_cur  = ctl_in;
            assign dn_cur   = dnorm;
            assign q_cur    = '0;
            assign lz_cur   = lz_in;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign trial    = {rem_reg[g-1], 1'b0};
            assign ctl_cur  = ctl_reg[g-1];
            assign dn_cur   = dn_reg[g-1];
            assign q_cur    = q_reg[g-1];
            assign lz_cur   = lz_reg[g-1];
            assign side_cur = side_reg[g-1];
        end

        // Compare, subtract and shift in one quotient bit
        always_comb
        begin
            diff     = trial - {1'b0, dn_cur};
            ge       = (trial >= {1'b0, dn_cur});
            rem_next = ge ? diff[NB-1:0] : trial[NB-1:0];
            q_next   = {q_cur[RW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[g] <= '0;
            end
            else if (en)
            begin
                ctl_reg[g] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                dn_reg[g]   <= dn_cur;
                q_reg[g]    <= q_next;
                lz_reg[g]   <= lz_cur;
                side_reg[g] <= side_cur;
            end
        end
    end

    assign ctl_out  = ctl_reg[RW-1];
    assign recip    = q_reg[RW-1];
    assign lz_out   = lz_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

// ----- design/mi3_scale.sv -----
// Scale cofactors by the reciprocal, round, saturate and sign the results; identity if singular
`timescale 1ns / 1ps

module mi3_scale #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  mi3_pkg::mi3_ctl_t                   ctl_in,
    input  logic [mi3_pkg::RECIP_W-1:0]         recip,
    input  logic [$clog2(3*ELEM_WIDTH+1)-1:0]   lz,
    input  logic [18*ELEM_WIDTH+8:0]            side,
    output mi3_pkg::mi3_ctl_t                   ctl_out,
    output mi3_pkg::mi3_res_t                   res
);

    localparam int NE    = mi3_pkg::NUM_ELEM;
    localparam int OW    = mi3_pkg::OUT_W;
    localparam int CM    = 2 * ELEM_WIDTH;
    localparam int NB    = 3 * ELEM_WIDTH + 1;
    localparam int NCH   = (CM + 31) / 32;
    localparam int PADW  = NCH * 32;
    localparam int PW    = PADW + mi3_pkg::RECIP_W;
    localparam int SBASE = NB + mi3_pkg::RND_BASE - (ELEM_WIDTH - mi3_pkg::INT_BITS);
    localparam int SHW   = $clog2(SBASE + 1);

    mi3_pkg::mi3_ctl_t ctl_reg [5];

    logic [63:0]      pp_reg   [NE][NCH][2];
    logic [NE-1:0]    neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [SHW-1:0]   sh1_reg, sh2_reg, sh3_reg;
    logic [PW-1:0]    lo_reg   [NE];
    logic [PW-1:0]    hi_reg   [NE];
    logic [PW:0]      prod_reg [NE];
    logic [PW:0]      mag_reg  [NE];
    mi3_pkg::mi3_res_t res_reg;

    logic [PADW-1:0]  mag_pad  [NE];
    logic [SHW-1:0]   sh_next;
    logic [PW-1:0]    lo_next  [NE];
    logic [PW-1:0]    hi_next  [NE];
    logic [PW:0]      half;
    logic [PW:0]      prod_next [NE];
    logic [PW:0]      lim      [NE];
    logic [NE-1:0]    sat;
    logic [OW-1:0]    val      [NE];
    mi3_pkg::mi3_res_t res_next;

    // Advance the control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 5; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s < 5; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    always_comb
    begin
        sh_next = SHW'(SBASE) - SHW'(lz);
        for (int i = 0; i < NE; i++)
        begin
            mag_pad[i] = PADW'(side[CM*i +: CM]);
        end

        // Sum the partial products of each reciprocal half
        for (int i = 0; i < NE; i++)
        begin
            lo_next[i] = '0;
            hi_next[i] = '0;
            for (int c = 0; c < NCH; c++)
            begin
                lo_next[i] = lo_next[i] + (PW'(pp_reg[i][c][0]) << (32 * c));
                hi_next[i] = hi_next[i] + (PW'(pp_reg[i][c][1]) << (32 * c));
            end
        end

        // Join the halves and add the rounding bit
        half = (PW+1)'(1) << (sh2_reg - 1'b1);
        for (int i = 0; i < NE; i++)
        begin
            prod_next[i] = {1'b0, lo_reg[i]} + ({1'b0, hi_reg[i]} << 32) + half;
        end

        // Clip to the signed 32-bit range and apply the sign
        res_next.singular  = ctl_reg[3].singular;
        res_next.saturated = 1'b0;
        for (int i = 0; i < NE; i++)
        begin
            lim[i] = neg4_reg[i] ? (PW+1)'(mi3_pkg::NEG_LIMIT)
                                 : (PW+1)'(mi3_pkg::POS_LIMIT);
            sat[i] = (mag_reg[i] > lim[i]);
            val[i] = sat[i] ? lim[i][OW-1:0] : mag_reg[i][OW-1:0];
            if (ctl_reg[3].singular)
            begin
                res_next.elem[i] = mi3_pkg::ident_elem(i);
            end
            else
            begin
                res_next.elem[i] = neg4_reg[i] ? (OW'(0) - val[i]) : val[i];
            end
        end
        if (!ctl_reg[3].singular)
        begin
            res_next.saturated = |sat;
        end
    end

    // Hold the payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NE; i++)
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    pp_reg[i][c][0] <= 64'(mag_pad[i][32*c +: 32]) * 64'(recip[31:0]);
                    pp_reg[i][c][1] <= 64'(mag_pad[i][32*c +: 32]) * 64'(recip[63:32]);
                end
                lo_reg[i]   <= lo_next[i];
                hi_reg[i]   <= hi_next[i];
                prod_reg[i] <= prod_next[i];
                mag_reg[i]  <= prod_reg[i] >> sh3_reg;
            end
            neg1_reg <= side[NE*CM +: NE];
            neg2_reg <= neg1_reg;
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            sh1_reg  <= sh_next;
            sh2_reg  <= sh1_reg;
            sh3_reg  <= sh2_reg;
            res_reg  <= res_next;
        end
    end

    assign ctl_out = ctl_reg[4];
    assign res     = res_reg;

endmodule

// ----- design/matrix_inverse_3x3.sv -----
// Throughput: one matrix per cycle unless the output buffer is full; the 64-stage reciprocal divider sets the depth.
// The whole pipeline advances together while the two-entry output buffer has room,
// so in_ready depends only on registered state.
// Reset clears all valid bits and the output buffer; data registers are not reset.
`timescale 1ns / 1ps
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r0c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r1c2,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c0,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c1,
    input  logic signed [ELEM_WIDTH-1:0] in_r2c2,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           out_r0c0,
    output logic signed [31:0]           out_r0c1,
    output logic signed [31:0]           out_r0c2,
    output logic signed [31:0]           out_r1c0,
    output logic signed [31:0]           out_r1c1,
    output logic signed [31:0]           out_r1c2,
    output logic signed [31:0]           out_r2c0,
    output logic signed [31:0]           out_r2c1,
    output logic signed [31:0]           out_r2c2,
    output logic                         singular,
    output logic                         saturated
);

    localparam int NB  = 3 * ELEM_WIDTH + 1;
    localparam int NSH = $clog2(NB);
    localparam int SW  = 18 * ELEM_WIDTH + 9;

    logic signed [ELEM_WIDTH-1:0] elem [mi3_pkg::NUM_ELEM];

    mi3_pkg::mi3_ctl_t cof_ctl, norm_ctl, div_ctl, scl_ctl;
    logic [NB-1:0]     dmag, dnorm;
    logic [NSH-1:0]    norm_lz, div_lz;
    logic [SW-1:0]     cof_side, norm_side, div_side;
    logic [mi3_pkg::RECIP_W-1:0] recip;
    mi3_pkg::mi3_res_t scl_res;

    mi3_pkg::mi3_res_t buf_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              en, push, pop;
    mi3_pkg::mi3_res_t head;

    assign elem[0] = in_r0c0;
    assign elem[1] = in_r0c1;
    assign elem[2] = in_r0c2;
    assign elem[3] = in_r1c0;
    assign elem[4] = in_r1c1;
    assign elem[5] = in_r1c2;
    assign elem[6] = in_r2c0;
    assign elem[7] = in_r2c1;
    assign elem[8] = in_r2c2;

    // Advance the pipeline while the output buffer can take one more result
    assign en       = (count_reg != 2'd2);
    assign in_ready = en;
    assign push     = en && scl_ctl.valid;
    assign pop      = out_valid && out_ready;

    mi3_cof #(.ELEM_WIDTH(ELEM_WIDTH)) u_cof (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .elem     (elem),
        .ctl      (cof_ctl),
        .dmag     (dmag),
        .side     (cof_side)
    );

    mi3_norm #(.ELEM_WIDTH(ELEM_WIDTH)) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (cof_ctl),
        .dmag     (dmag),
        .side_in  (cof_side),
        .ctl_out  (norm_ctl),
        .dnorm    (dnorm),
        .lz       (norm_lz),
        .side_out (norm_side)
    );

    mi3_div #(.ELEM_WIDTH(ELEM_WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctl_in   (norm_ctl),
        .dnorm    (dnorm),
        .lz_in    (norm_lz),
        .side_in  (norm_side),
        .ctl_out  (div_ctl),
        .recip    (recip),
        .lz_out   (div_lz),
        .side_out (div_side)
    );

    mi3_scale #(.ELEM_WIDTH(ELEM_WIDTH)) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (div_ctl),
        .recip   (recip),
        .lz      (div_lz),
        .side    (div_side),
        .ctl_out (scl_ctl),
        .res     (scl_res)
    );

    // Track buffer occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store finished results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= scl_res;
        end
    end

    // Present the oldest result
    assign head      = buf_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign out_r0c0  = head.elem[0];
    assign out_r0c1  = head.elem[1];
    assign out_r0c2  = head.elem[2];
    assign out_r1c0  = head.elem[3];
    assign out_r1c1  = head.elem[4];
    assign out_r1c2  = head.elem[5];
    assign out_r2c0  = head.elem[6];
    assign out_r2c1  = head.elem[7];
    assign out_r2c2  = head.elem[8];
    assign singular  = head.singular;
    assign saturated = head.saturated;

    `MI3_ASSERT_SAME(a_count_range, 1'b1, count_reg != 2'd3, "output buffer count out of range")
    `MI3_ASSERT_NEXT(a_pop_count, pop && !push, count_reg == $past(count_reg) - 2'd1, "transfer out did not drop count")
    `MI3_ASSERT_SAME(a_sing_ident, out_valid && singular, !saturated && out_r0c0 == mi3_pkg::ONE_Q16 && out_r1c1 == mi3_pkg::ONE_Q16 && out_r0c1 == 32'sd0, "singular result is not identity")

endmodule

// ----- tb/sv/mi3_checker.sv -----
// Scoreboard for the 3x3 matrix inverse: predicts each inverse and checks the results
`timescale 1ns / 1ps

module mi3_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [8:0][15:0]             in_elems,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [8:0][31:0]             out_elems,
    input  logic                         singular,
    input  logic                         saturated,
    output int                           fail_count,
    output int                           pending
);

    mi3_pkg::mi3_res_t inverse_q[$];

    // Compute the scaled adjugate of one matrix, elements row by row
    function automatic mi3_pkg::mi3_res_t invert_matrix(input logic [8:0][15:0] m);
        longint       e [9];
        longint       cof [9];
        longint       det;
        logic [127:0] dmag;
        logic [127:0] recip;
        logic [127:0] cmag;
        logic [127:0] mag;
        logic [127:0] limit;
        int           len;
        int           sh;
        logic         neg;
        mi3_pkg::mi3_res_t r;
        for (int i = 0; i < 9; i++)
            e[i] = longint'($signed(m[i]));
        cof[0] = e[4] * e[8] - e[7] * e[5];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[3] * e[2] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[6] * e[4];
        cof[7] = e[6] * e[1] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        r = '0;
        // Return identity on a zero determinant
        if (det == 0) begin
            for (int i = 0; i < 9; i++)
                r.elem[i] = (i % 4 == 0) ? mi3_pkg::ONE_Q16 : '0;
            r.singular = 1'b1;
            return r;
        end
        dmag = (det < 0) ? 128'(-det) : 128'(det);
        len = 0;
        while ((dmag >> len) != 0)
            len++;
        recip = (128'd1 << (len + 62)) / dmag;
        sh = len + 46 - (16 - mi3_pkg::INT_BITS);
        for (int i = 0; i < 9; i++) begin
            cmag = (cof[i] < 0) ? 128'(-cof[i]) : 128'(cof[i]);
            neg = (cof[i] < 0) != (det < 0);
            mag = (cmag * recip + (128'd1 << (sh - 1))) >> sh;
            limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (mag > limit) begin
                mag = limit;
                r.saturated = 1'b1;
            end
            r.elem[i] = neg ? -mag[31:0] : mag[31:0];
        end
        return r;
    endfunction

    assign pending = inverse_q.size();

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        mi3_pkg::mi3_res_t exp_r;
        logic     bad;
        if (!rst_n) begin
            fail_count <= 0;
        end else begin
            if (in_valid && in_ready)
                inverse_q.push_back(invert_matrix(in_elems));
            if (out_valid && out_ready) begin
                if (inverse_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer at %0t", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = inverse_q.pop_front();
                    bad = (exp_r.singular !== singular) || (exp_r.saturated !== saturated);
                    for (int i = 0; i < 9; i++)
                        if (exp_r.elem[i] !== out_elems[i])
                            bad = 1'b1;
                    if (bad) begin
                        if (fail_count < 10) begin
                            $display("mismatch at %0t: singular exp %b got %b, saturated exp %b got %b",
                                     $realtime, exp_r.singular, singular,
                                     exp_r.saturated, saturated);
                            for (int i = 0; i < 9; i++)
                                $display("  element %0d exp %h got %h", i, exp_r.elem[i],
                                         out_elems[i]);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_matrix_inverse_3x3.sv -----
// Testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_matrix_inverse_3x3;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_ITEMS   = 500;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [8:0][15:0]   mat;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] o [9];
    logic               singular;
    logic               saturated;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    logic [8:0][15:0]   m;

    matrix_inverse_3x3 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_r0c0   (mat[0]),
        .in_r0c1   (mat[1]),
        .in_r0c2   (mat[2]),
        .in_r1c0   (mat[3]),
        .in_r1c1   (mat[4]),
        .in_r1c2   (mat[5]),
        .in_r2c0   (mat[6]),
        .in_r2c1   (mat[7]),
        .in_r2c2   (mat[8]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_r0c0  (o[0]),
        .out_r0c1  (o[1]),
        .out_r0c2  (o[2]),
        .out_r1c0  (o[3]),
        .out_r1c1  (o[4]),
        .out_r1c2  (o[5]),
        .out_r2c0  (o[6]),
        .out_r2c1  (o[7]),
        .out_r2c2  (o[8]),
        .singular  (singular),
        .saturated (saturated)
    );

    mi3_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_elems   (mat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_elems  ({o[8], o[7], o[6], o[5], o[4], o[3], o[2], o[1], o[0]}),
        .singular   (singular),
        .saturated  (saturated),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Stall the receiver in random-length runs of a random mode
    always @(posedge clk)
    begin
        int mode;
        int run;
        if (run == 0) begin
            run = $urandom_range(5, 60);
            mode = $urandom_range(0, 3);
        end
        run--;
        case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= 1'b0;
        endcase
    end

    // End the run when transfers stop while results are owed
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (pending == 0 && !in_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_matrix_inverse_3x3: FAIL");
            $finish;
        end
    end

    // Hold one matrix on the input until its transfer
    task automatic send_matrix(input logic [8:0][15:0] a);
        in_valid <= 1'b1;
        mat <= a;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pause_input(input int n);
        in_valid <= 1'b0;
        mat <= 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [8:0][15:0] diag_matrix(input logic [15:0] a, input logic [15:0] b,
                                                     input logic [15:0] c);
        logic [8:0][15:0] r;
        r = '0;
        r[0] = a;
        r[4] = b;
        r[8] = c;
        return r;
    endfunction

    // Draw a random matrix of one of several shapes
    function automatic logic [8:0][15:0] random_matrix();
        logic [8:0][15:0] r;
        int               kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            r[i] = $urandom;
        case (kind)
            0, 1, 2: ;
            3, 4: begin
                // Dominant diagonal near unit scale
                for (int i = 0; i < 9; i++)
                    r[i] = 16'($signed($urandom_range(0, 2048)) - 1024);
                r[0] = r[0] + 16'd4096;
                r[4] = r[4] - 16'd4096;
                r[8] = r[8] + 16'd4096;
            end
            5: begin
                for (int i = 0; i < 9; i++)
                    r[i] = 16'($signed($urandom_range(0, 8)) - 4);
            end
            6: begin
                // Repeated row: singular
                r[6] = r[0];
                r[7] = r[1];
                r[8] = r[2];
            end
            7: begin
                for (int i = 0; i < 9; i++)
                    r[i] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            end
            default: begin
                r[3] = 16'd0;
                r[6] = 16'd0;
                r[7] = 16'd0;
            end
        endcase
        return r;
    endfunction

    initial begin
        in_valid = 1'b0;
        mat = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed matrices
        send_matrix('0);
        send_matrix(diag_matrix(16'd4096, 16'd4096, 16'd4096));
        send_matrix(diag_matrix(16'hF000, 16'hF000, 16'hF000));
        send_matrix(diag_matrix(16'hF000, 16'd4096, 16'd4096));
        send_matrix(diag_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_matrix(diag_matrix(16'h8000, 16'h8000, 16'h8000));
        send_matrix(diag_matrix(16'd1, 16'd1, 16'd1));
        send_matrix(diag_matrix(16'hFFFF, 16'd1, 16'd1));
        send_matrix(diag_matrix(16'h7FFF, 16'h8000, 16'd1));
        send_matrix({9{16'h8000}});
        send_matrix({9{16'h7FFF}});
        send_matrix({9{16'hFFFF}});
        // Row swap of identity: negative determinant
        m = '0;
        m[1] = 16'd4096;
        m[3] = 16'd4096;
        m[8] = 16'd4096;
        send_matrix(m);
        m = '0;
        m[2] = 16'h8000;
        m[4] = 16'h7FFF;
        m[6] = 16'h8000;
        send_matrix(m);
        m = diag_matrix(16'd4096, 16'd4096, 16'd4096);
        m[1] = 16'h7FFF;
        m[2] = 16'h8000;
        m[5] = 16'h7FFF;
        send_matrix(m);
        send_matrix({16'd9, 16'd8, 16'd7, 16'd6, 16'd5, 16'd4, 16'd3, 16'd2, 16'd1});

        // Drain before the random part
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);

        // Random matrices in bursts with gaps
        for (int n = 0; n < RANDOM_ITEMS;) begin
            int burst;
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++)
                send_matrix(random_matrix());
            if ($urandom_range(0, 2) != 0)
                pause_input($urandom_range(1, 12));
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_matrix_inverse_3x3: PASS");
        else
            $display("tb_matrix_inverse_3x3: FAIL");
        $finish;
    end

endmodule
